FILE: rtl/core/mladc_pkg.sv
package mladc_pkg;

    localparam int IDX_W = 4;
    localparam int VAL_W = 32;
    localparam int LIU_W = 5;

    localparam logic [LIU_W-1:0] LIU_RESET = 5'd16;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_DUMP   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [1:0] ST_ELEMENT   = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    typedef struct packed {
        logic [1:0]              kind;
        logic [IDX_W-1:0]        list_index;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] element;
        logic [1:0]              status;
        logic                    last;
    } t_out_item;

    // Output stage status seen by the sequencer.
    typedef struct packed {
        logic pend_free;   // the read data stage is empty at the next edge
        logic res_ok;      // a status result may be loaded this cycle
    } t_out_stat;

    // Element read issued toward the output stage.
    typedef struct packed {
        logic issue;
        logic last;
    } t_rd_req;

    // Status-only result from the sequencer.
    typedef struct packed {
        logic       load;
        logic [1:0] status;
    } t_result;

endpackage

FILE: rtl/core/mladc_store.sv
module mladc_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds its value until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/mladc_ctrl.sv
module mladc_ctrl #(
    parameter int NUM_LISTS  = 16,
    parameter int LIST_DEPTH = 64,
    parameter int ADDR_W     = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  mladc_pkg::t_in_item                i_in_item,
    input  logic                               i_cfg_we,
    input  logic [mladc_pkg::LIU_W-1:0]        i_cfg_wdata,
    input  mladc_pkg::t_out_stat               i_stat,
    output mladc_pkg::t_rd_req                 o_rd_req,
    output logic [ADDR_W-1:0]                  o_rd_addr,
    output mladc_pkg::t_result                 o_res,
    output logic                               o_wr_en,
    output logic [ADDR_W-1:0]                  o_wr_addr,
    output logic [mladc_pkg::VAL_W-1:0]        o_wr_data
);

    import mladc_pkg::*;

    localparam int LU        = (NUM_LISTS < 16) ? NUM_LISTS : 16;
    localparam int LIDX_W    = (LU > 1) ? $clog2(LU) : 1;
    localparam int LEN_DEPTH = 1 << LIDX_W;
    localparam int LEN_W     = $clog2(LIST_DEPTH + 1);

    localparam logic [LIU_W-1:0]  LU_C    = LIU_W'(LU);
    localparam logic [LEN_W-1:0]  DEPTH_L = LEN_W'(LIST_DEPTH);
    localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(LIST_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;

    logic [1:0]        r_state, n_state;
    t_in_item          r_item, n_item;
    logic [LIU_W-1:0]  r_liu;
    logic [LEN_W-1:0]  r_len [LEN_DEPTH];
    logic [LEN_W-1:0]  n_len [LEN_DEPTH];
    logic [LEN_W-1:0]  r_pos, n_pos;
    logic [LEN_W-1:0]  r_last_pos, n_last_pos;
    logic [ADDR_W-1:0] r_base, n_base;

    logic [LIDX_W-1:0] idx_l;
    logic [LEN_W-1:0]  cur_len;
    logic              bad;
    logic [ADDR_W-1:0] base;
    logic              dump_last;

    assign idx_l     = r_item.list_index[LIDX_W-1:0];
    assign cur_len   = r_len[idx_l];
    assign bad       = ({1'b0, r_item.list_index} >= r_liu) ||
                       ({1'b0, r_item.list_index} >= LU_C);
    assign base      = ADDR_W'(idx_l) * DEPTH_A;
    assign dump_last = (r_pos == r_last_pos);

    assign o_in_stall = (r_state != S_IDLE);
    assign o_wr_addr  = base + ADDR_W'(cur_len);
    assign o_wr_data  = r_item.value;
    assign o_rd_addr  = r_base + ADDR_W'(r_pos);

    always_comb begin
        n_state       = r_state;
        n_item        = r_item;
        n_len         = r_len;
        n_pos         = r_pos;
        n_last_pos    = r_last_pos;
        n_base        = r_base;
        o_wr_en       = 1'b0;
        o_rd_req      = '0;
        o_res.load    = 1'b0;
        o_res.status  = ST_ELEMENT;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_item.kind != KIND_APPEND && r_item.kind != KIND_DUMP &&
                    r_item.kind != KIND_CLEAR) begin
                    n_state = S_IDLE;
                end else if (bad) begin
                    if (i_stat.res_ok) begin
                        o_res.load   = 1'b1;
                        o_res.status = ST_BAD_INDEX;
                        n_state      = S_IDLE;
                    end
                end else begin
                    case (r_item.kind)
                        KIND_APPEND: begin
                            if (cur_len == DEPTH_L) begin
                                if (i_stat.res_ok) begin
                                    o_res.load   = 1'b1;
                                    o_res.status = ST_FULL;
                                    n_state      = S_IDLE;
                                end
                            end else begin
                                o_wr_en      = 1'b1;
                                n_len[idx_l] = cur_len + LEN_W'(1);
                                n_state      = S_IDLE;
                            end
                        end
                        KIND_CLEAR: begin
                            n_len[idx_l] = '0;
                            n_state      = S_IDLE;
                        end
                        KIND_DUMP: begin
                            if (cur_len == '0) begin
                                if (i_stat.res_ok) begin
                                    o_res.load   = 1'b1;
                                    o_res.status = ST_EMPTY;
                                    n_state      = S_IDLE;
                                end
                            end else begin
                                n_pos      = '0;
                                n_last_pos = cur_len - LEN_W'(1);
                                n_base     = base;
                                n_state    = S_DUMP;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                // One read per cycle while the read data stage can drain.
                if (i_stat.pend_free) begin
                    o_rd_req.issue = 1'b1;
                    o_rd_req.last  = dump_last;
                    n_pos          = r_pos + LEN_W'(1);
                    if (dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_liu   <= LIU_RESET;
            for (int i = 0; i < LEN_DEPTH; i++) begin
                r_len[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            if (i_cfg_we) begin
                r_liu <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_pos      <= n_pos;
        r_last_pos <= n_last_pos;
        r_base     <= n_base;
    end

endmodule

FILE: rtl/core/multi_list_append_dump_clear.sv
// Append and clear produce no result; the input stalls while an item is in progress.
// A rejected item gives its one result from the sequencer's execute state.
// A dump of n elements streams one element per cycle from the element memory
// while the output is not stalled, via the read register and output register.
// Reset empties every list and sets lists_in_use to 16; the element memory
// is not cleared, since only entries below a list's length are ever read.
module multi_list_append_dump_clear #(
    parameter int NUM_LISTS  = 16,
    parameter int LIST_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  mladc_pkg::t_in_item          i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output mladc_pkg::t_out_item         o_out_item,
    input  logic                         i_cfg_we,
    input  logic [mladc_pkg::LIU_W-1:0]  i_cfg_wdata
);

    import mladc_pkg::*;

    localparam int LU        = (NUM_LISTS < 16) ? NUM_LISTS : 16;
    localparam int MEM_DEPTH = LU * LIST_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    t_out_stat         stat;
    t_rd_req           rd_req;
    t_result           res;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic [VAL_W-1:0]  rd_data;

    logic              r_pend, n_pend;
    logic              r_pend_last, n_pend_last;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;
    logic              out_free;
    logic              move;

    mladc_ctrl #(
        .NUM_LISTS  (NUM_LISTS),
        .LIST_DEPTH (LIST_DEPTH),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stat      (stat),
        .o_rd_req    (rd_req),
        .o_rd_addr   (rd_addr),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    mladc_store #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (VAL_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_req.issue),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // The memory read register is a holding stage ahead of the output register.
    assign out_free       = !r_out_valid || !i_out_stall;
    assign move           = r_pend && out_free;
    assign stat.pend_free = !r_pend || move;
    assign stat.res_ok    = !r_pend && out_free;

    always_comb begin
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (rd_req.issue) begin
            n_pend      = 1'b1;
            n_pend_last = rd_req.last;
        end else if (move) begin
            n_pend = 1'b0;
        end

        if (move) begin
            n_out_valid     = 1'b1;
            n_out.element   = rd_data;
            n_out.status    = ST_ELEMENT;
            n_out.last      = r_pend_last;
        end else if (res.load) begin
            n_out_valid     = 1'b1;
            n_out.element   = '0;
            n_out.status    = res.status;
            n_out.last      = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_last <= n_pend_last;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: dv/tb.sv
module tb;
    import mladc_pkg::*;

    localparam int N_LISTS     = 16;
    localparam int DEPTH       = 64;
    localparam int QUIET_LIMIT = 4000;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_in_item         i_in_item   = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_item        o_out_item;
    logic             i_cfg_we    = 1'b0;
    logic [LIU_W-1:0] i_cfg_wdata = '0;

    // Mirror of the list bank as the block should hold it.
    logic [LIU_W-1:0]        mirror_lists_in_use = LIU_RESET;
    logic [6:0]              mirror_len [N_LISTS];
    logic signed [VAL_W-1:0] mirror_mem [N_LISTS][DEPTH];

    t_in_item  op_q[$];
    t_out_item due_out_q[$];

    int n_launched     = 0;
    int n_accepted     = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    multi_list_append_dump_clear #(
        .NUM_LISTS (N_LISTS),
        .LIST_DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Works out the results one accepted item causes and updates the mirror.
    task automatic apply_list_op(input t_in_item it);
        logic [6:0] n;
        t_out_item  r;
        r.element = '0;
        r.status  = ST_ELEMENT;
        r.last    = 1'b1;
        if (it.kind != KIND_APPEND && it.kind != KIND_DUMP && it.kind != KIND_CLEAR)
            return;
        if (it.list_index >= mirror_lists_in_use || it.list_index >= N_LISTS) begin
            r.status = ST_BAD_INDEX;
            due_out_q = {due_out_q, r};
            return;
        end
        n = mirror_len[it.list_index];
        case (it.kind)
            KIND_APPEND: begin
                if (n >= DEPTH) begin
                    r.status = ST_FULL;
                    due_out_q = {due_out_q, r};
                end else begin
                    mirror_mem[it.list_index][n] = it.value;
                    mirror_len[it.list_index] = n + 7'd1;
                end
            end
            KIND_CLEAR: begin
                mirror_len[it.list_index] = '0;
            end
            default: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                    due_out_q = {due_out_q, r};
                end else begin
                    for (int i = 0; i < n; i++) begin
                        r.element = mirror_mem[it.list_index][i];
                        r.last    = (i == n - 1);
                        due_out_q = {due_out_q, r};
                    end
                end
            end
        endcase
    endtask

    task automatic log_mismatch(input string what, input t_out_item want,
                                input t_out_item got);
        if (mismatches < 10)
            $display("%s: expected %0d/%0d/%0b, got %0d/%0d/%0b (element/status/last)",
                     what, want.element, want.status, want.last,
                     got.element, got.status, got.last);
        mismatches++;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
                            input logic [VAL_W-1:0] val);
        t_in_item it;
        it.kind       = kind;
        it.list_index = idx;
        it.value      = val;
        op_q = {op_q, it};
    endtask

    // Mostly append runs followed by a dump of the same list, with some noise.
    task automatic queue_mix(input int n);
        int               made;
        int               k;
        int               reach;
        logic [IDX_W-1:0] idx;
        made  = 0;
        reach = (mirror_lists_in_use > N_LISTS) ? N_LISTS : mirror_lists_in_use;
        while (made < n) begin
            if ($urandom_range(99) < 70) begin
                if (reach > 0 && $urandom_range(9) != 0)
                    idx = IDX_W'($urandom_range(reach - 1));
                else
                    idx = IDX_W'($urandom_range(15));
                k = $urandom_range(6);
                repeat (k) queue_op(KIND_APPEND, idx, pick_value());
                queue_op(KIND_DUMP, idx, $urandom);
                made += k + 1;
                if ($urandom_range(3) == 0) begin
                    queue_op(KIND_CLEAR, idx, $urandom);
                    made++;
                end
            end else begin
                queue_op(2'($urandom_range(3)), IDX_W'($urandom_range(15)), pick_value());
                made++;
            end
        end
    endtask

    // Appends and clears cause no result, so the task waits on past the last result for them to finish.
    task automatic wait_idle();
        while (op_q.size() != 0 || n_launched != n_accepted || due_out_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_lists_in_use(input logic [LIU_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we            <= 1'b1;
        i_cfg_wdata         <= v;
        mirror_lists_in_use = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                apply_list_op(i_in_item);
                n_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (op_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    i_in_item  <= op_q.pop_front();
                    i_in_valid <= 1'b1;
                    n_launched++;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_out_q.size() == 0)
                log_mismatch("result with none expected", '0, o_out_item);
            else if (o_out_item.element !== due_out_q[0].element ||
                     o_out_item.status !== due_out_q[0].status ||
                     o_out_item.last !== due_out_q[0].last)
                log_mismatch("wrong result", due_out_q.pop_front(), o_out_item);
            else
                void'(due_out_q.pop_front());
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("multi_list_append_dump_clear: mismatch");
        $finish;
    end

    initial begin
        foreach (mirror_len[i]) mirror_len[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items with all sixteen lists addressable.
        queue_op(KIND_DUMP, 4'd0, 32'h0);
        queue_op(KIND_APPEND, 4'd0, 32'h8000_0000);
        queue_op(KIND_APPEND, 4'd0, 32'h7fff_ffff);
        queue_op(KIND_APPEND, 4'd0, 32'h0);
        queue_op(KIND_APPEND, 4'd0, 32'hffff_ffff);
        queue_op(KIND_DUMP, 4'd0, 32'hffff_ffff);
        queue_op(KIND_APPEND, 4'd15, 32'h5555_5555);
        queue_op(KIND_APPEND, 4'd15, 32'haaaa_aaaa);
        queue_op(KIND_DUMP, 4'd15, 32'h0);
        queue_op(KIND_CLEAR, 4'd0, 32'h0);
        queue_op(KIND_DUMP, 4'd0, 32'h0);
        queue_op(KIND_CLEAR, 4'd15, 32'hffff_ffff);
        queue_op(KIND_DUMP, 4'd15, 32'h0);
        queue_op(KIND_UNUSED, 4'd15, 32'hffff_ffff);
        queue_op(KIND_UNUSED, 4'd0, 32'h0);
        queue_op(KIND_APPEND, 4'd7, 32'h1);
        queue_op(KIND_DUMP, 4'd7, 32'h0);
        queue_op(KIND_CLEAR, 4'd9, 32'h0);
        wait_idle();

        // Only list 0 addressable: any other index of a valid kind is a bad index.
        set_lists_in_use(5'd1);
        queue_op(KIND_APPEND, 4'd0, 32'h1234_5678);
        queue_op(KIND_APPEND, 4'd1, 32'h1);
        queue_op(KIND_DUMP, 4'd15, 32'h0);
        queue_op(KIND_CLEAR, 4'd8, 32'h0);
        queue_op(KIND_UNUSED, 4'd15, 32'h0);
        queue_op(KIND_DUMP, 4'd0, 32'h0);
        wait_idle();

        // Fill list 3 to the top, overflow it twice, and dump it whole.
        set_lists_in_use(5'd16);
        for (int j = 0; j <= DEPTH; j++) queue_op(KIND_APPEND, 4'd3, pick_value());
        queue_op(KIND_APPEND, 4'd3, pick_value());
        queue_op(KIND_DUMP, 4'd3, 32'h0);
        queue_mix(50);
        wait_idle();

        set_lists_in_use(5'd31);
        send_gap_pct = 79;
        queue_mix(40);
        wait_idle();
        queue_mix(40);
        wait_idle();

        set_lists_in_use(5'd5);
        send_gap_pct   = 0;
        recv_stall_pct = 79;
        queue_op(KIND_DUMP, 4'd3, 32'h0);
        queue_op(KIND_CLEAR, 4'd3, 32'h0);
        queue_mix(80);
        wait_idle();

        set_lists_in_use(5'd0);
        send_gap_pct   = 11;
        recv_stall_pct = 11;
        queue_mix(15);
        wait_idle();

        set_lists_in_use(5'd17);
        queue_mix(45);
        wait_idle();

        if (mismatches == 0 && due_out_q.size() == 0)
            $display("multi_list_append_dump_clear: match");
        else
            $display("multi_list_append_dump_clear: mismatch");
        $finish;
    end

endmodule

FILE: multi_list_append_dump_clear.f
rtl/core/mladc_pkg.sv
rtl/core/mladc_store.sv
rtl/core/mladc_ctrl.sv
rtl/core/multi_list_append_dump_clear.sv
dv/tb.sv
